FILE: rtl/core/qse_pkg.sv
// shared types, constants and escape encoder for the quoted string escaper
`default_nettype none

package qse_pkg;

  localparam logic [7:0] QUOTE_CH  = 8'h22;
  localparam logic [7:0] BSLASH_CH = 8'h5C;
  localparam logic [7:0] NL_CH     = 8'h0A;
  localparam logic [7:0] ZERO_CH   = 8'h30;
  localparam logic [7:0] NINE_CH   = 8'h39;
  localparam logic [7:0] DEL_CH    = 8'h7F;
  localparam logic [7:0] CTL_LIMIT = 8'd32;
  localparam logic [7:0] HUNDRED   = 8'd100;
  localparam logic [6:0] TEN       = 7'd10;
  localparam logic [12:0] RECIP_TEN = 13'd205;
  localparam int RECIP_SHIFT = 11;

  // job queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // escaped form of one byte, 1 to 4 bytes long
  typedef struct packed {
    logic [2:0]      len;
    logic [3:0][7:0] bytes;
  } esc_seq_t;

  // everything one input item emits, in order:
  // seg_a, closing quote (close_a), seg_b plus its closing quote, two quotes (two_q)
  typedef struct packed {
    esc_seq_t seg_a;
    logic     close_a;
    esc_seq_t seg_b;
    logic     two_q;
  } qse_job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qse_q_stat_t;

  typedef enum logic [2:0] {
    P_A,
    P_CA,
    P_B,
    P_CB,
    P_Q1,
    P_Q2
  } qse_part_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= ZERO_CH) && (c <= NINE_CH);
  endfunction

  function automatic esc_seq_t esc_encode(input logic [7:0] c, input logic next_digit);
    esc_seq_t   s;
    logic       hund;
    logic       three;
    logic [6:0] rem;
    logic [12:0] prod;
    logic [3:0] tens;
    logic [3:0] ones;
    hund  = (c == DEL_CH);
    three = hund || next_digit;
    rem   = hund ? 7'(c - HUNDRED) : c[6:0];
    // divide by ten via the reciprocal; rem is below 32 where digits are used
    prod  = 13'(rem) * RECIP_TEN;
    tens  = 4'(prod >> RECIP_SHIFT);
    ones  = 4'(rem - 7'(tens) * TEN);
    s       = '0;
    s.len   = 3'd1;
    s.bytes[0] = c;
    if (c == QUOTE_CH || c == BSLASH_CH || c == NL_CH) begin
      s.len      = 3'd2;
      s.bytes[0] = BSLASH_CH;
      s.bytes[1] = c;
    end else if (c < CTL_LIMIT || hund) begin
      s.bytes[0] = BSLASH_CH;
      if (three) begin
        s.len      = 3'd4;
        s.bytes[1] = ZERO_CH + {7'd0, hund};
        s.bytes[2] = ZERO_CH + {4'd0, tens};
        s.bytes[3] = ZERO_CH + {4'd0, ones};
      end else if (rem >= TEN) begin
        s.len      = 3'd3;
        s.bytes[1] = ZERO_CH + {4'd0, tens};
        s.bytes[2] = ZERO_CH + {4'd0, ones};
      end else begin
        s.len      = 3'd2;
        s.bytes[1] = ZERO_CH + {4'd0, ones};
      end
    end
    return s;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/qse_ifs.sv
// valid/ready channel interfaces for input bytes and escaped output bytes
`default_nettype none

interface qse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       empty_string;

  modport source(output valid, data_byte, last_byte, empty_string, input ready);
  modport sink(input valid, data_byte, last_byte, empty_string, output ready);
endinterface

interface qse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source(output valid, out_byte, run_end, string_end, input ready);
  modport sink(input valid, out_byte, run_end, string_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/qse_front.sv
// front end: accepts input bytes, keeps the lookahead byte, builds one job per item
`default_nettype none

module qse_front import qse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  qse_in_if.sink      in_ch,
  input  qse_q_stat_t q_stat,
  output logic        push,
  output qse_job_t    push_job
);

  logic [7:0] held_byte_r, held_byte_nxt;
  logic       held_valid_r, held_valid_nxt;
  esc_seq_t   open_seq;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && in_ch.ready;

  always_comb begin
    open_seq          = '0;
    open_seq.len      = 3'd1;
    open_seq.bytes[0] = QUOTE_CH;

    push_job       = '0;
    held_byte_nxt  = held_byte_r;
    held_valid_nxt = held_valid_r;

    if (in_ch.empty_string) begin
      // close any pending string, then two quotes
      push_job.seg_a   = held_valid_r ? esc_encode(held_byte_r, 1'b0) : open_seq;
      push_job.close_a = 1'b1;
      push_job.two_q   = held_valid_r;
      if (push) begin
        held_valid_nxt = 1'b0;
      end
    end else begin
      push_job.seg_a = held_valid_r ? esc_encode(held_byte_r, is_digit(in_ch.data_byte))
                                    : open_seq;
      if (in_ch.last_byte) begin
        push_job.seg_b = esc_encode(in_ch.data_byte, 1'b0);
      end
      if (push) begin
        held_byte_nxt  = in_ch.data_byte;
        held_valid_nxt = !in_ch.last_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r <= 1'b0;
    end else begin
      held_valid_r <= held_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_byte_r <= held_byte_nxt;
  end

endmodule

`default_nettype wire

FILE: rtl/core/qse_fifo.sv
// short job queue between the front and back ends
`default_nettype none

module qse_fifo import qse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  qse_job_t    push_job,
  input  logic        pop,
  output qse_job_t    head_job,
  output qse_q_stat_t q_stat
);

  qse_job_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign head_job     = mem_r[rd_ptr_r];
  assign q_stat.full  = (cnt_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/qse_back.sv
// back end: walks the head job, emits one byte per cycle unless stalled
`default_nettype none

module qse_back import qse_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  qse_job_t    head_job,
  input  qse_q_stat_t q_stat,
  output logic        pop,
  qse_out_if.source   out_ch
);

  qse_part_t  part_r, part_nxt;
  logic [1:0] idx_r, idx_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       run_end_r, run_end_nxt;
  logic       string_end_r, string_end_nxt;

  logic       emit;
  logic       last;
  logic       seg_more;
  logic       has_next;
  qse_part_t  next_part;
  logic [7:0] cur_byte;
  logic       cur_str_end;

  always_comb begin
    cur_byte    = QUOTE_CH;
    cur_str_end = 1'b0;
    seg_more    = 1'b0;
    has_next    = 1'b0;
    next_part   = P_A;

    case (part_r)
      P_A: begin
        cur_byte = head_job.seg_a.bytes[idx_r];
        seg_more = ({1'b0, idx_r} + 3'd1) < head_job.seg_a.len;
        if (head_job.close_a) begin
          has_next  = 1'b1;
          next_part = P_CA;
        end else if (head_job.seg_b.len != '0) begin
          has_next  = 1'b1;
          next_part = P_B;
        end else if (head_job.two_q) begin
          has_next  = 1'b1;
          next_part = P_Q1;
        end
      end
      P_CA: begin
        cur_str_end = 1'b1;
        if (head_job.seg_b.len != '0) begin
          has_next  = 1'b1;
          next_part = P_B;
        end else if (head_job.two_q) begin
          has_next  = 1'b1;
          next_part = P_Q1;
        end
      end
      P_B: begin
        cur_byte  = head_job.seg_b.bytes[idx_r];
        seg_more  = ({1'b0, idx_r} + 3'd1) < head_job.seg_b.len;
        has_next  = 1'b1;
        next_part = P_CB;
      end
      P_CB: begin
        cur_str_end = 1'b1;
        if (head_job.two_q) begin
          has_next  = 1'b1;
          next_part = P_Q1;
        end
      end
      P_Q1: begin
        has_next  = 1'b1;
        next_part = P_Q2;
      end
      P_Q2: begin
        cur_str_end = 1'b1;
      end
      default: begin
        cur_str_end = 1'b0;
      end
    endcase

    emit = !q_stat.empty && (!out_valid_r || out_ch.ready);
    last = !seg_more && !has_next;
    pop  = emit && last;

    part_nxt = part_r;
    idx_nxt  = idx_r;
    if (emit) begin
      if (seg_more) begin
        idx_nxt = idx_r + 2'd1;
      end else if (has_next) begin
        part_nxt = next_part;
        idx_nxt  = '0;
      end else begin
        part_nxt = P_A;
        idx_nxt  = '0;
      end
    end

    out_valid_nxt  = out_valid_r;
    out_byte_nxt   = out_byte_r;
    run_end_nxt    = run_end_r;
    string_end_nxt = string_end_r;
    if (emit) begin
      out_valid_nxt  = 1'b1;
      out_byte_nxt   = cur_byte;
      run_end_nxt    = last;
      string_end_nxt = cur_str_end;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r      <= P_A;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      part_r      <= part_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    run_end_r    <= run_end_nxt;
    string_end_r <= string_end_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_byte   = out_byte_r;
  assign out_ch.run_end    = run_end_r;
  assign out_ch.string_end = string_end_r;

endmodule

`default_nettype wire

FILE: rtl/core/quoted_string_escaper_unit.sv
// top level of the quoted string escaper: front end, job queue, back end
// an accepted item goes into the job queue; its first byte then enters the output register
// throughput: one output byte per cycle unless stalled or the job queue is empty; an item
//   emits 1 to 9 bytes (one for a plain byte, up to 4 for an escaped byte)
// input is taken every cycle while the two-entry job queue has room
// reset (rst_n low, synchronous) empties the queue and output register, drops the held byte
`default_nettype none

module quoted_string_escaper_unit import qse_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  qse_in_if.sink    in_ch,
  qse_out_if.source out_ch
);

  // front to queue
  logic        push;
  qse_job_t    push_job;

  // queue to back
  qse_job_t    head_job;
  qse_q_stat_t q_stat;
  logic        pop;

  // classify bytes, hold one byte back for its lookahead
  qse_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_job (push_job)
  );

  // decouples input transfers from output stalls
  qse_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head_job (head_job),
    .q_stat   (q_stat)
  );

  // sequence the job bytes into the output register
  qse_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head_job (head_job),
    .q_stat   (q_stat),
    .pop      (pop),
    .out_ch   (out_ch)
  );

  // queue status never claims both full and empty
  a_q_stat_sane: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_stat.full && q_stat.empty))
    else $error("job queue full and empty at once");

  // retiring a job always loads the final byte of its run
  a_pop_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (out_ch.valid && out_ch.run_end))
    else $error("job retired without run end byte");

  // a closing quote is the only byte flagged as string end
  a_end_is_quote: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.string_end) |-> (out_ch.out_byte == QUOTE_CH))
    else $error("string end on a byte other than a quote");

  // no input transfer while the queue is full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.full |-> !push)
    else $error("push into a full job queue");

endmodule

`default_nettype wire
